// ===== rtl/dfs_pkg.sv =====
package dfs_pkg;

    // Default table depth
    localparam int MAX_ENTRIES_DEF = 32;

    // Field and datapath widths
    localparam int POS_W   = 10;
    localparam int KEY_W   = 8;
    localparam int COORD_W = 11;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SCORE_W = COORD_W + 2;

    // A candidate must lie further than this off the focused centre
    localparam int NEAR_MARGIN = 2;

    // Request codes
    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_SET = 2'd1;
    localparam logic [1:0] REQ_NAV = 2'd2;
    localparam logic [1:0] REQ_KEY = 2'd3;

    // Navigate directions
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // One stored target
    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [KEY_W-1:0]   key;
    } entry_t;

    // Sequencer to score unit
    typedef struct packed {
        logic clear;
        logic valid;
        logic navigate;
    } scan_ctl_t;

    // Score unit back to sequencer
    typedef struct packed {
        logic found;
        logic busy;
    } scan_stat_t;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FREAD  = 6'b000010,
        S_FLOAD  = 6'b000100,
        S_SCAN   = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

endpackage

// ===== rtl/dfs_table.sv =====
module dfs_table
    import dfs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    localparam int IDX_W = $clog2(MAX_ENTRIES)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/dfs_score_unit.sv =====
module dfs_score_unit
    import dfs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    localparam int IDX_W = $clog2(MAX_ENTRIES)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  scan_ctl_t          ctl,
    input  logic [IDX_W-1:0]   idx,
    input  entry_t             entry,
    input  logic [COORD_W-1:0] focus_x,
    input  logic [COORD_W-1:0] focus_y,
    input  logic [IDX_W-1:0]   focus_idx,
    input  logic [1:0]         dir,
    input  logic [KEY_W-1:0]   key,
    output scan_stat_t         stat,
    output logic [IDX_W-1:0]   best_idx
);

    localparam logic signed [DIFF_W-1:0] MARGIN_POS = DIFF_W'(NEAR_MARGIN);
    localparam logic signed [DIFF_W-1:0] MARGIN_NEG = -MARGIN_POS;

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] ndx;
    logic signed [DIFF_W-1:0] ndy;
    logic [DIFF_W-1:0]        abs_dx;
    logic [DIFF_W-1:0]        abs_dy;
    logic                     ok;
    logic [COORD_W-1:0]       along;
    logic [COORD_W-1:0]       perp;
    logic                     match;

    logic                     a_valid_reg;
    logic [IDX_W-1:0]         a_idx_reg;
    logic                     a_ok_reg;
    logic                     a_match_reg;
    logic                     a_nav_reg;
    logic [COORD_W-1:0]       a_along_reg;
    logic [COORD_W-1:0]       a_perp_reg;

    logic [SCORE_W-1:0]       score;
    logic                     found_reg;
    logic [SCORE_W-1:0]       best_score_reg;
    logic [IDX_W-1:0]         best_idx_reg;

    // Offsets from the focused centre and their magnitudes
    always_comb
    begin
        dx     = $signed({1'b0, entry.cx}) - $signed({1'b0, focus_x});
        dy     = $signed({1'b0, entry.cy}) - $signed({1'b0, focus_y});
        ndx    = -dx;
        ndy    = -dy;
        abs_dx = dx[DIFF_W-1] ? ndx : dx;
        abs_dy = dy[DIFF_W-1] ? ndy : dy;
    end

    // Pick the along and perpendicular distances for the direction
    always_comb
    begin
        case (dir)
            DIR_UP:
            begin
                ok    = dy < MARGIN_NEG;
                along = COORD_W'(ndy);
                perp  = COORD_W'(abs_dx);
            end
            DIR_DOWN:
            begin
                ok    = dy > MARGIN_POS;
                along = COORD_W'(dy);
                perp  = COORD_W'(abs_dx);
            end
            DIR_LEFT:
            begin
                ok    = dx < MARGIN_NEG;
                along = COORD_W'(ndx);
                perp  = COORD_W'(abs_dy);
            end
            default:
            begin
                ok    = dx > MARGIN_POS;
                along = COORD_W'(dx);
                perp  = COORD_W'(abs_dy);
            end
        endcase
        match = (key != '0) && (entry.key == key);
    end

    // Stage A: register the distances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_idx_reg   <= idx;
        a_ok_reg    <= ok && (idx != focus_idx);
        a_match_reg <= match;
        a_nav_reg   <= ctl.navigate;
        a_along_reg <= along;
        a_perp_reg  <= perp;
    end

    // Stage B: score is along plus three times perpendicular
    assign score = {2'b00, a_along_reg} + {1'b0, a_perp_reg, 1'b0} + {2'b00, a_perp_reg};

    // Keep the first lowest score, or the first hotkey match
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (a_valid_reg)
        begin
            if (a_nav_reg)
            begin
                if (a_ok_reg && (!found_reg || score < best_score_reg))
                begin
                    found_reg <= 1'b1;
                end
            end
            else if (a_match_reg)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && !ctl.clear)
        begin
            if (a_nav_reg)
            begin
                if (a_ok_reg && (!found_reg || score < best_score_reg))
                begin
                    best_score_reg <= score;
                    best_idx_reg   <= a_idx_reg;
                end
            end
            else if (a_match_reg && !found_reg)
            begin
                best_idx_reg <= a_idx_reg;
            end
        end
    end

    assign stat.found = found_reg;
    assign stat.busy  = a_valid_reg;
    assign best_idx   = best_idx_reg;

endmodule

// ===== rtl/directional_focus_selector.sv =====
// Directional focus selector: a table of up to MAX_ENTRIES screen targets
// (centre point and hotkey) and a focus index, driven by one request word at
// a time and answering each with one result word. Add and set-focus requests,
// and navigate requests on an empty table or an out-of-range focus, go
// straight from acceptance to the result state. Other navigate requests
// first read the focused entry; they and hotkey requests then scan the
// table: its single read port delivers one entry per cycle to a shared
// two-stage score and match unit. The block takes no new request until the
// result word has been taken. The table needs no clearing after reset.
module directional_focus_selector
    import dfs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       req_type,
    input  logic [POS_W-1:0] pos_x,
    input  logic [POS_W-1:0] pos_y,
    input  logic [POS_W-1:0] box_width,
    input  logic [POS_W-1:0] box_height,
    input  logic [KEY_W-1:0] key_code,
    input  logic [1:0]       direction,
    input  logic [4:0]       target_index,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [4:0]       focus_index,
    output logic             hit,
    output logic [5:0]       entry_count
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = CNT_W + 5;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   focus_reg, focus_next;
    logic               hit_reg, hit_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               nav_reg;
    logic [1:0]         dir_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [COORD_W-1:0] fx_reg;
    logic [COORD_W-1:0] fy_reg;

    logic               accept;
    logic               wr_en;
    entry_t             wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    entry_t             rd_data;
    scan_ctl_t          ctl;
    scan_stat_t         stat;
    logic [IDX_W-1:0]   best_idx;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESULT);

    // New entry: centre is edge plus half the size
    assign wr_data.cx  = {1'b0, pos_x} + {2'b00, box_width[POS_W-1:1]};
    assign wr_data.cy  = {1'b0, pos_y} + {2'b00, box_height[POS_W-1:1]};
    assign wr_data.key = key_code;

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        focus_next    = focus_reg;
        hit_next      = hit_reg;
        scan_next     = scan_reg;
        rd_valid_next = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = scan_reg[IDX_W-1:0];
        ctl.clear     = 1'b0;
        ctl.valid     = rd_valid_reg;
        ctl.navigate  = nav_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    hit_next   = 1'b0;
                    scan_next  = '0;
                    ctl.clear  = 1'b1;
                    state_next = S_RESULT;
                    case (req_type)
                        REQ_ADD:
                        begin
                            if (count_reg < CNT_W'(MAX_ENTRIES))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                                hit_next   = 1'b1;
                            end
                        end
                        REQ_SET:
                        begin
                            if (CMP_W'(target_index) < CMP_W'(count_reg))
                            begin
                                focus_next = IDX_W'(target_index);
                                hit_next   = 1'b1;
                            end
                        end
                        REQ_NAV:
                        begin
                            if (count_reg == '0)
                            begin
                                hit_next = 1'b0;
                            end
                            else if (CNT_W'(focus_reg) >= count_reg)
                            begin
                                focus_next = '0;
                                hit_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_FREAD;
                            end
                        end
                        default:
                        begin
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end
            S_FREAD:
            begin
                rd_en      = 1'b1;
                rd_addr    = focus_reg;
                state_next = S_FLOAD;
            end
            S_FLOAD:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_reg < count_reg)
                begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    scan_next     = scan_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!rd_valid_reg && !stat.busy)
                begin
                    hit_next = stat.found;
                    if (stat.found)
                    begin
                        focus_next = best_idx;
                    end
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            focus_reg    <= '0;
            hit_reg      <= 1'b0;
            scan_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            focus_reg    <= focus_next;
            hit_reg      <= hit_next;
            scan_reg     <= scan_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // Hold request fields, track the index of the entry being read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            nav_reg <= (req_type == REQ_NAV);
            dir_reg <= direction;
            key_reg <= key_code;
        end
        if (state_reg == S_FLOAD)
        begin
            fx_reg <= rd_data.cx;
            fy_reg <= rd_data.cy;
        end
        rd_idx_reg <= scan_reg[IDX_W-1:0];
    end

    dfs_table #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dfs_score_unit #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_score (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .idx       (rd_idx_reg),
        .entry     (rd_data),
        .focus_x   (fx_reg),
        .focus_y   (fy_reg),
        .focus_idx (focus_reg),
        .dir       (dir_reg),
        .key       (key_reg),
        .stat      (stat),
        .best_idx  (best_idx)
    );

    // Result word
    assign focus_index = 5'(focus_reg);
    assign hit         = hit_reg;
    assign entry_count = 6'(count_reg);

endmodule
